### rtl/reservoir_level_step_core_assert.svh
// ---------------------------------------------------------------------------
// Reservoir level step core assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef RESERVOIR_LEVEL_STEP_CORE_ASSERT_SVH
`define RESERVOIR_LEVEL_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RLSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RLSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RLSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define RLSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/rls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step package
// Widths, fixed-point constants, control codes and the ctrl/datapath structs.
// ---------------------------------------------------------------------------
package rls_pkg;

   localparam int LEVEL_W = 30;
   localparam int FLOW_W  = 24;
   localparam int STEP_W  = 20;
   localparam int VOL_W   = 44;
   localparam int X_W     = 42;
   localparam int SQ_W    = 52;

   localparam logic [STEP_W-1:0] STEP_RESET = 20'd86400;

   // rating curve coefficients, Q.32 rounded to nearest
   localparam logic [63:0]        COEF_A = 64'd97925254;
   localparam logic [63:0]        COEF_B = 64'd22892605184;
   localparam logic signed [63:0] COEF_C = 64'sd1347115633397;
   // floor(2^64 / 1e8)
   localparam logic [63:0]        FLOW_K = 64'd184467440737;

   localparam logic [X_W-1:0]   X_START0 = {10'd300, 32'd0};
   localparam logic [X_W-1:0]   X_START1 = {10'd500, 32'd0};
   localparam logic [X_W-1:0]   X_MAX    = {X_W{1'b1}};
   localparam logic [VOL_W-1:0] VOL_MAX  = {VOL_W{1'b1}};
   localparam logic [63:0]      STEP_CAP = 64'h0000_0800_0000_0000;
   localparam logic [63:0]      RES_TOL  = 64'd64;

   typedef enum logic [2:0] {
      MUL_SQ, MUL_A, MUL_B, MUL_F1, MUL_F2, MUL_SEC
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_VOL_UPD, OP_SETVOL, OP_R0, OP_R1,
      OP_NEXT, OP_CONV, OP_LEVEL, OP_RESP
   } dp_op_type;

   typedef enum logic [1:0] {
      RET_SET, RET_R0, RET_R1I, RET_ITER
   } curve_ret_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISP, ST_FLOW1, ST_FLOW2, ST_VOL, ST_CSQ, ST_CA, ST_CB,
      ST_CRET, ST_CHK_DEN, ST_SMUL, ST_DIV, ST_CHK_RES, ST_LEVEL, ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        div_start;
      dp_op_type   op;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic req_type;
      logic den_zero;
      logic res_ok;
   } dp_status_type;

endpackage

### rtl/rls_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step request channel
// valid/ready channel carrying one request.
// ---------------------------------------------------------------------------
interface rls_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [rls_pkg::LEVEL_W-1:0]   level_in;
   logic [rls_pkg::FLOW_W-1:0]    inflow_total;
   logic [rls_pkg::FLOW_W-1:0]    outflow_total;

   modport source (output valid, req_type, level_in, inflow_total, outflow_total,
                   input ready);
   modport sink   (input valid, req_type, level_in, inflow_total, outflow_total,
                   output ready);
endinterface

### rtl/rls_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step response channel
// valid/ready channel carrying one response.
// ---------------------------------------------------------------------------
interface rls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rls_pkg::LEVEL_W-1:0]   level_out;
   logic                          converged;
   logic                          volume_clamped;

   modport source (output valid, level_out, converged, volume_clamped, input ready);
   modport sink   (input valid, level_out, converged, volume_clamped, output ready);
endinterface

### rtl/rls_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step multiplier
// 64x64 unsigned multiply, four multiplier bits per cycle.
// ---------------------------------------------------------------------------
module rls_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a_in,
   input  logic [63:0]   b_in,
   output logic [127:0]  prod,
   output logic          done
);
   localparam int DIG_W = 4;
   localparam int STEPS = 64 / DIG_W;

   logic [63:0]          a_ff, b_ff;
   logic [127:0]         p_ff;
   logic [3:0]           cnt_ff;
   logic                 busy_ff, done_ff;
   logic [64+DIG_W-1:0]  part, sum;

   assign part = a_ff * b_ff[DIG_W-1:0];
   assign sum  = {{DIG_W{1'b0}}, p_ff[127:64]} + part;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 4'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a_in;
         b_ff <= b_in;
         p_ff <= '0;
      end else if (busy_ff) begin
         p_ff <= {sum, p_ff[63:DIG_W]};
         b_ff <= {{DIG_W{1'b0}}, b_ff[63:DIG_W]};
      end
   end

   assign prod = p_ff;
   assign done = done_ff;
endmodule

### rtl/rls_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step divider
// Restoring 128/64 divide, one quotient bit per cycle, saturating result.
// ---------------------------------------------------------------------------
module rls_div (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [127:0]  num,
   input  logic [63:0]   den,
   output logic [63:0]   quot,
   output logic          done
);
   logic [63:0] rem_ff, lo_ff, q_ff, den_ff, res_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [64:0] rem_sh, rem_sub;
   logic        ge;
   logic [63:0] q_fin;

   assign rem_sh  = {rem_ff, lo_ff[63]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   assign q_fin   = {q_ff[62:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= '0;
            if (num[127:64] >= den) begin
               done_ff <= 1'b1;     // quotient too large: saturate at once
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[127:64];
         lo_ff  <= num[63:0];
         den_ff <= den;
         q_ff   <= '0;
         res_ff <= rls_pkg::STEP_CAP;
      end else if (busy_ff) begin
         rem_ff <= rem_sub[63:0];
         lo_ff  <= {lo_ff[62:0], 1'b0};
         q_ff   <= q_fin;
         if (cnt_ff == 6'd63) begin
            res_ff <= (q_fin > rls_pkg::STEP_CAP) ? rls_pkg::STEP_CAP : q_fin;
         end
      end
   end

   assign quot = res_ff;
   assign done = done_ff;
endmodule

### rtl/rls_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step datapath
// Volume/level state, curve terms, secant registers, shared mul, and div.
// ---------------------------------------------------------------------------
module rls_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rls_pkg::STEP_W-1:0]      csr_wr_data,
   input  logic                            req_type,
   input  logic [rls_pkg::LEVEL_W-1:0]     level_in,
   input  logic [rls_pkg::FLOW_W-1:0]      inflow_total,
   input  logic [rls_pkg::FLOW_W-1:0]      outflow_total,
   input  rls_pkg::dp_cmd_type             cmd,
   output rls_pkg::dp_status_type          sts,
   output logic [rls_pkg::LEVEL_W-1:0]     level_out,
   output logic                            converged,
   output logic                            volume_clamped
);
   logic [rls_pkg::STEP_W-1:0]  step_ff;
   logic [rls_pkg::VOL_W-1:0]   vol_ff;
   logic [rls_pkg::LEVEL_W-1:0] level_ff;
   logic                        typ_ff;
   logic [rls_pkg::FLOW_W-1:0]  in_ff, out_ff;
   logic [rls_pkg::X_W-1:0]     cx_ff, x0_ff, x1_ff;
   logic signed [63:0]          r0_ff, r1_ff, cv_ff;
   logic [rls_pkg::SQ_W-1:0]    sq_ff;
   logic [46:0]                 t2_ff;
   logic [43:0]                 prod44_ff;
   logic [41:0]                 delta_ff;
   logic                        conv_ff, clamp_ff;
   logic [rls_pkg::LEVEL_W-1:0] olevel_ff;
   logic                        oconv_ff, oclamp_ff;

   logic [63:0]  mul_a, mul_b;
   logic [127:0] mprod;
   logic         mul_done;
   logic [63:0]  dquot;
   logic         div_done;

   logic                        flow_neg;
   logic [rls_pkg::FLOW_W-1:0]  flow_mag;
   logic signed [63:0]          den, r_new;
   logic [63:0]                 den_mag, r1_mag;
   logic [42:0]                 dx, dx_mag;
   logic                        step_neg;
   logic signed [45:0]          x1e, qe, xn_raw;
   logic [rls_pkg::X_W-1:0]     xn;
   logic [44:0]                 vol_sum;
   logic [rls_pkg::VOL_W-1:0]   vol_set;

   assign flow_neg = out_ff > in_ff;
   assign flow_mag = flow_neg ? (out_ff - in_ff) : (in_ff - out_ff);
   assign den      = r1_ff - r0_ff;
   assign den_mag  = den[63] ? (64'd0 - den) : den;
   assign r1_mag   = r1_ff[63] ? (64'd0 - r1_ff) : r1_ff;
   assign dx       = {1'b0, x1_ff} - {1'b0, x0_ff};
   assign dx_mag   = dx[42] ? (43'd0 - dx) : dx;
   assign r_new    = cv_ff - $signed({20'd0, vol_ff});
   assign vol_sum  = {1'b0, vol_ff} + {3'd0, delta_ff};

   // secant update: x1 -/+ step, kept inside 0 .. X_MAX
   assign step_neg = r1_ff[63] ^ dx[42] ^ den[63];
   assign x1e      = $signed({4'd0, x1_ff});
   assign qe       = $signed({2'd0, dquot[43:0]});
   assign xn_raw   = step_neg ? (x1e + qe) : (x1e - qe);

   always_comb begin
      if (xn_raw < 0) begin
         xn = '0;
      end else if (xn_raw > $signed({4'd0, rls_pkg::X_MAX})) begin
         xn = rls_pkg::X_MAX;
      end else begin
         xn = xn_raw[rls_pkg::X_W-1:0];
      end
   end

   always_comb begin
      if (cv_ff < 0) begin
         vol_set = '0;
      end else if (cv_ff > $signed({20'd0, rls_pkg::VOL_MAX})) begin
         vol_set = rls_pkg::VOL_MAX;
      end else begin
         vol_set = cv_ff[rls_pkg::VOL_W-1:0];
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         rls_pkg::MUL_SQ: begin
            mul_a = {22'd0, cx_ff};
            mul_b = {22'd0, cx_ff};
         end
         rls_pkg::MUL_A: begin
            mul_a = rls_pkg::COEF_A;
            mul_b = {12'd0, sq_ff};
         end
         rls_pkg::MUL_B: begin
            mul_a = rls_pkg::COEF_B;
            mul_b = {22'd0, cx_ff};
         end
         rls_pkg::MUL_F1: begin
            mul_a = {44'd0, step_ff};
            mul_b = {40'd0, flow_mag};
         end
         rls_pkg::MUL_F2: begin
            mul_a = {20'd0, prod44_ff};
            mul_b = rls_pkg::FLOW_K;
         end
         rls_pkg::MUL_SEC: begin
            mul_a = r1_mag;
            mul_b = {21'd0, dx_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   rls_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .prod  (mprod),
      .done  (mul_done)
   );

   rls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (mprod),
      .den   (den_mag),
      .quot  (dquot),
      .done  (div_done)
   );

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= rls_pkg::STEP_RESET;
         vol_ff   <= '0;
         level_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         case (cmd.op)
            rls_pkg::OP_CAPTURE: begin
               if (!req_type) begin
                  level_ff <= level_in;
               end
            end
            rls_pkg::OP_VOL_UPD: begin
               if (flow_neg) begin
                  if ({2'd0, delta_ff} > vol_ff) begin
                     vol_ff <= '0;
                  end else begin
                     vol_ff <= vol_ff - {2'd0, delta_ff};
                  end
               end else if (vol_sum > {1'b0, rls_pkg::VOL_MAX}) begin
                  vol_ff <= rls_pkg::VOL_MAX;
               end else begin
                  vol_ff <= vol_sum[rls_pkg::VOL_W-1:0];
               end
            end
            rls_pkg::OP_SETVOL: vol_ff   <= vol_set;
            rls_pkg::OP_LEVEL:  level_ff <= x1_ff[rls_pkg::X_W-1:12];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.mul_sel)
            rls_pkg::MUL_SQ:  sq_ff     <= mprod[83:32];
            rls_pkg::MUL_A:   t2_ff     <= mprod[78:32];
            rls_pkg::MUL_B:   cv_ff     <= $signed({17'd0, t2_ff})
                                           - $signed({19'd0, mprod[76:32]})
                                           + rls_pkg::COEF_C;
            rls_pkg::MUL_F1:  prod44_ff <= mprod[43:0];
            rls_pkg::MUL_F2:  delta_ff  <= mprod[81:40];
            default: ;
         endcase
      end
      case (cmd.op)
         rls_pkg::OP_CAPTURE: begin
            typ_ff   <= req_type;
            in_ff    <= inflow_total;
            out_ff   <= outflow_total;
            conv_ff  <= 1'b0;
            clamp_ff <= 1'b0;
            cx_ff    <= {level_in, 12'd0};
         end
         rls_pkg::OP_VOL_UPD: begin
            if (flow_neg && ({2'd0, delta_ff} > vol_ff)) begin
               clamp_ff <= 1'b1;
            end
            x0_ff <= rls_pkg::X_START0;
            x1_ff <= rls_pkg::X_START1;
            cx_ff <= rls_pkg::X_START0;
         end
         rls_pkg::OP_R0: begin
            r0_ff <= r_new;
            cx_ff <= x1_ff;
         end
         rls_pkg::OP_R1: r1_ff <= r_new;
         rls_pkg::OP_NEXT: begin
            x0_ff <= x1_ff;
            r0_ff <= r1_ff;
            x1_ff <= xn;
            cx_ff <= xn;
         end
         rls_pkg::OP_CONV: conv_ff <= 1'b1;
         rls_pkg::OP_RESP: begin
            olevel_ff <= level_ff;
            oconv_ff  <= conv_ff;
            oclamp_ff <= clamp_ff;
         end
         default: ;
      endcase
   end

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;
   assign sts.req_type = typ_ff;
   assign sts.den_zero = (r1_ff == r0_ff);
   assign sts.res_ok   = (r1_mag <= rls_pkg::RES_TOL);

   assign level_out      = olevel_ff;
   assign converged      = oconv_ff;
   assign volume_clamped = oclamp_ff;
endmodule

### rtl/rls_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step controller
// Sequences volume update, curve evaluation and secant rounds.
// ---------------------------------------------------------------------------
`include "reservoir_level_step_core_assert.svh"
module rls_ctrl #(
   parameter int MAX_ITER = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rls_pkg::dp_status_type  sts,
   output rls_pkg::dp_cmd_type     cmd
);
   localparam int ITER_W = $clog2(MAX_ITER + 1);

   rls_pkg::ctrl_state_type state_ff, state_in;
   rls_pkg::curve_ret_type  ret_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic                    mul_iss_ff, div_iss_ff, rsp_valid_ff;
   logic                    out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rls_pkg::ST_IDLE:    if (req_valid) state_in = rls_pkg::ST_DISP;
         rls_pkg::ST_DISP:    state_in = sts.req_type ? rls_pkg::ST_FLOW1 : rls_pkg::ST_CSQ;
         rls_pkg::ST_FLOW1:   if (sts.mul_done) state_in = rls_pkg::ST_FLOW2;
         rls_pkg::ST_FLOW2:   if (sts.mul_done) state_in = rls_pkg::ST_VOL;
         rls_pkg::ST_VOL:     state_in = rls_pkg::ST_CSQ;
         rls_pkg::ST_CSQ:     if (sts.mul_done) state_in = rls_pkg::ST_CA;
         rls_pkg::ST_CA:      if (sts.mul_done) state_in = rls_pkg::ST_CB;
         rls_pkg::ST_CB:      if (sts.mul_done) state_in = rls_pkg::ST_CRET;
         rls_pkg::ST_CRET: begin
            case (ret_ff)
               rls_pkg::RET_SET:  state_in = rls_pkg::ST_RESP;
               rls_pkg::RET_R0:   state_in = rls_pkg::ST_CSQ;
               rls_pkg::RET_R1I:  state_in = rls_pkg::ST_CHK_DEN;
               default:           state_in = rls_pkg::ST_CHK_RES;
            endcase
         end
         rls_pkg::ST_CHK_DEN: state_in = sts.den_zero ? rls_pkg::ST_LEVEL : rls_pkg::ST_SMUL;
         rls_pkg::ST_SMUL:    if (sts.mul_done) state_in = rls_pkg::ST_DIV;
         rls_pkg::ST_DIV:     if (sts.div_done) state_in = rls_pkg::ST_CSQ;
         rls_pkg::ST_CHK_RES: begin
            if (sts.res_ok || (iter_ff == ITER_W'(MAX_ITER))) begin
               state_in = rls_pkg::ST_LEVEL;
            end else begin
               state_in = rls_pkg::ST_CHK_DEN;
            end
         end
         rls_pkg::ST_LEVEL:   state_in = rls_pkg::ST_RESP;
         rls_pkg::ST_RESP:    if (out_free) state_in = rls_pkg::ST_IDLE;
         default:             state_in = rls_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.mul_start = 1'b0;
      cmd.mul_sel   = rls_pkg::MUL_SQ;
      cmd.div_start = 1'b0;
      cmd.op        = rls_pkg::OP_NONE;
      case (state_ff)
         rls_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = rls_pkg::OP_CAPTURE;
         end
         rls_pkg::ST_FLOW1: begin
            cmd.mul_sel   = rls_pkg::MUL_F1;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_FLOW2: begin
            cmd.mul_sel   = rls_pkg::MUL_F2;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_VOL:  cmd.op = rls_pkg::OP_VOL_UPD;
         rls_pkg::ST_CSQ: begin
            cmd.mul_sel   = rls_pkg::MUL_SQ;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_CA: begin
            cmd.mul_sel   = rls_pkg::MUL_A;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_CB: begin
            cmd.mul_sel   = rls_pkg::MUL_B;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_CRET: begin
            case (ret_ff)
               rls_pkg::RET_SET: cmd.op = rls_pkg::OP_SETVOL;
               rls_pkg::RET_R0:  cmd.op = rls_pkg::OP_R0;
               default:          cmd.op = rls_pkg::OP_R1;
            endcase
         end
         rls_pkg::ST_SMUL: begin
            cmd.mul_sel   = rls_pkg::MUL_SEC;
            cmd.mul_start = !mul_iss_ff;
         end
         rls_pkg::ST_DIV: begin
            cmd.div_start = !div_iss_ff;
            if (sts.div_done) cmd.op = rls_pkg::OP_NEXT;
         end
         rls_pkg::ST_CHK_RES: if (sts.res_ok) cmd.op = rls_pkg::OP_CONV;
         rls_pkg::ST_LEVEL:   cmd.op = rls_pkg::OP_LEVEL;
         rls_pkg::ST_RESP:    if (out_free) cmd.op = rls_pkg::OP_RESP;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rls_pkg::ST_IDLE;
         ret_ff       <= rls_pkg::RET_SET;
         iter_ff      <= '0;
         mul_iss_ff   <= 1'b0;
         div_iss_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.mul_start) begin
            mul_iss_ff <= 1'b1;
         end else if (sts.mul_done) begin
            mul_iss_ff <= 1'b0;
         end
         if (cmd.div_start) begin
            div_iss_ff <= 1'b1;
         end else if (sts.div_done) begin
            div_iss_ff <= 1'b0;
         end
         if ((state_ff == rls_pkg::ST_DISP) && !sts.req_type) begin
            ret_ff <= rls_pkg::RET_SET;
         end
         if (state_ff == rls_pkg::ST_VOL) begin
            ret_ff <= rls_pkg::RET_R0;
         end
         if ((state_ff == rls_pkg::ST_CRET) && (ret_ff == rls_pkg::RET_R0)) begin
            ret_ff <= rls_pkg::RET_R1I;
         end
         if ((state_ff == rls_pkg::ST_CRET) && (ret_ff == rls_pkg::RET_R1I)) begin
            iter_ff <= '0;
         end
         if ((state_ff == rls_pkg::ST_DIV) && sts.div_done) begin
            ret_ff  <= rls_pkg::RET_ITER;
            iter_ff <= iter_ff + 1'b1;
         end
         if (cmd.op == rls_pkg::OP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RLSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, state_ff != rls_pkg::ST_IDLE)
   `RLSC_ASSERT_IMPLY(a_iter_bound, clock, reset, state_ff == rls_pkg::ST_SMUL, iter_ff < ITER_W'(MAX_ITER))
   `RLSC_ASSERT_IMPLY(a_mul_done_issued, clock, reset, sts.mul_done, mul_iss_ff)
endmodule

### rtl/reservoir_level_step_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reservoir level step core
// Keeps reservoir volume, converts it to water level by secant inversion.
// ---------------------------------------------------------------------------
// One request at a time. A set-level request loads the level and derives the
// volume from the rating curve. A step request updates the volume, evaluates
// the curve at both start points and then runs up to MAX_ITER secant rounds,
// each using the shared multiplier (4 bits per cycle, four products per round)
// and the divider (1 quotient bit per cycle). The response sits in an output
// register, so the next request is taken as soon as the core returns to idle,
// even if the previous response is unread. The user must write step_seconds
// (csr_wr_data) only while the core is idle; the core does not enforce this.
module reservoir_level_step_core #(
   parameter int MAX_ITER = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rls_pkg::STEP_W-1:0]  csr_wr_data,
   rls_req_if.sink                     req_ch,
   rls_rsp_if.source                   rsp_ch
);
   rls_pkg::dp_cmd_type    cmd;
   rls_pkg::dp_status_type sts;

   // controller: request/response handshake and sequencing
   rls_ctrl #(
      .MAX_ITER (MAX_ITER)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: state, arithmetic units and response payload
   rls_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_type       (req_ch.req_type),
      .level_in       (req_ch.level_in),
      .inflow_total   (req_ch.inflow_total),
      .outflow_total  (req_ch.outflow_total),
      .cmd            (cmd),
      .sts            (sts),
      .level_out      (rsp_ch.level_out),
      .converged      (rsp_ch.converged),
      .volume_clamped (rsp_ch.volume_clamped)
   );
endmodule
